// ===== rtl/rgbf_pkg.sv =====
// Shared widths, codes and palette sizing for the RGB LED blink/fade engine.
`default_nettype none

package rgbf_pkg;

  localparam int PALETTE_DEPTH = 10;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int PCNT_W        = 4;
  localparam int CNT_W         = ($clog2(PALETTE_DEPTH + 1) > PCNT_W) ?
                                 $clog2(PALETTE_DEPTH + 1) : PCNT_W;

  localparam int FUNC_W     = 2;
  localparam int CH_W       = 8;
  localparam int DELTA_W    = 9;
  localparam int COLOR_W    = 4 * CH_W;
  localparam int MODE_W     = 2;
  localparam int EL_W       = 13;
  localparam int EL_X_W     = EL_W + 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADJ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FADE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd2;

  localparam logic [MODE_W-1:0]  MODE_RST     = MODE_STATIC;
  localparam logic [EL_W-1:0]    INTERVAL_RST = 13'd1000;
  localparam logic [PCNT_W-1:0]  COUNT_RST    = 4'd2;
  localparam logic [EL_W-1:0]    EL_MAX       = '1;
  localparam logic [EL_X_W-1:0]  FADE_SCALE   = 20'd100;

  typedef logic [COLOR_W-1:0] color_t;

endpackage

`default_nettype wire

// ===== rtl/rgbf_if.sv =====
// Channel interfaces: item input, duty output and register write port.
`default_nettype none

interface rgbf_in_if
  import rgbf_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [CH_W-1:0]           red;
  logic [CH_W-1:0]           green;
  logic [CH_W-1:0]           blue;
  logic [CH_W-1:0]           lum;
  logic                      lum_valid;
  logic signed [DELTA_W-1:0] delta;

  modport source (output valid, func, red, green, blue, lum, lum_valid, delta,
                  input ready);
  modport sink   (input valid, func, red, green, blue, lum, lum_valid, delta,
                  output ready);
endinterface

interface rgbf_out_if
  import rgbf_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] duty_red;
  logic [CH_W-1:0] duty_green;
  logic [CH_W-1:0] duty_blue;

  modport source (output valid, duty_red, duty_green, duty_blue, input ready);
  modport sink   (input valid, duty_red, duty_green, duty_blue, output ready);
endinterface

interface rgbf_cfg_if
  import rgbf_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_led_blink_fade_engine_top.sv =====
// RGB LED blink/fade engine: palette memory, color sequencer and duty scaler.
//
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+----------------
//  in_ch    | in  | func, red, green, blue, lum, lum_valid, delta    | valid && ready
//  out_ch   | out | duty_red, duty_green, duty_blue                  | valid && ready
//  cfg_ch   | in  | index, data (mode, blink_interval, palette_count)| valid && ready
//
// One item at a time. Static/set/adjust/no-step tick: accept, then 3 duty passes
// through the shared 8x8 multiply-and-divide-by-255 unit. Blink step adds a palette
// write/read and a load. Fade step adds two palette reads on the single read port
// and four byte blends through the same unit.
// Synchronous active-low reset; palette entries read as zero until written.
// A stalled output holds the last duty pass; cfg_ch is always ready.
`default_nettype none

module rgb_led_blink_fade_engine_top
  import rgbf_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  rgbf_in_if.sink     in_ch,
  rgbf_out_if.source  out_ch,
  rgbf_cfg_if.sink    cfg_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLINK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FADE  = 3'd3;
  localparam logic [2:0] S_FRDB  = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_DUTY  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [EL_W-1:0]   interval_r;
  logic [PCNT_W-1:0] count_r;
  color_t            cur_r, cur_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CH_W-1:0]   phase_r, phase_nxt;
  logic [EL_W-1:0]   el_r, el_nxt;
  logic              out_valid_r, outv_nxt;

  color_t                   pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_ok_r;
  color_t                   rd_data_r;
  logic                     rd_ok_r;
  color_t                   rd_word;
  logic                     wr_en, rd_en;
  logic [IDX_W-1:0]         rd_addr;

  color_t          a_r;
  logic [CH_W-1:0] dty_r [2];
  logic [CH_W-1:0] duty_red_r, duty_green_r, duty_blue_r;
  logic            a_ld, dty_ld, out_ld;

  logic [CNT_W-1:0]  cnt_ext, n_slots, idx_p1;
  logic [IDX_W-1:0]  bidx, fidx;
  logic [EL_W-1:0]   el_inc;
  logic [EL_X_W-1:0] el_x100;
  logic              blink_hit, fade_hit;
  logic signed [9:0] lum_sum;
  logic [CH_W-1:0]   lum_adj;

  logic [CH_W-1:0] ma, mb, mc, md;
  logic [15:0]     sc_sum;
  logic [16:0]     sc_t;
  logic [CH_W-1:0] sc_q;

  assign rd_word = rd_ok_r ? rd_data_r : '0;

  assign cnt_ext = CNT_W'(count_r);
  assign n_slots = (cnt_ext < CNT_W'(2)) ? CNT_W'(2) :
                   (cnt_ext > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : cnt_ext;
  assign idx_p1  = CNT_W'(idx_r) + CNT_W'(1);
  assign bidx    = (idx_p1 < n_slots) ? IDX_W'(idx_p1) : '0;
  assign fidx    = (phase_r == 8'hFF) ? bidx : idx_r;

  assign el_inc    = (el_r == EL_MAX) ? el_r : el_r + EL_W'(1);
  assign el_x100   = EL_X_W'(el_inc) * FADE_SCALE;
  assign blink_hit = el_inc > interval_r;
  assign fade_hit  = el_x100 > EL_X_W'(interval_r);

  assign lum_sum = $signed({2'b00, cur_r[31:24]}) + $signed({in_ch.delta[8], in_ch.delta});
  assign lum_adj = (lum_sum < 10'sd1) ? 8'd1 :
                   (lum_sum > 10'sd255) ? 8'hFF : lum_sum[7:0];

  always_comb begin
    if (state_r == S_MIX) begin
      ma = 8'hFF - phase_r;
      mb = a_r[k_r*8 +: 8];
      mc = phase_r;
      md = rd_word[k_r*8 +: 8];
    end else begin
      ma = cur_r[k_r*8 +: 8];
      mb = cur_r[31:24];
      mc = '0;
      md = '0;
    end
  end

  // x/255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
  assign sc_sum = ({8'd0, ma} * {8'd0, mb}) + ({8'd0, mc} * {8'd0, md});
  assign sc_t   = {1'b0, sc_sum} + {9'd0, sc_sum[15:8]} + 17'd1;
  assign sc_q   = sc_t[15:8];

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    el_nxt    = el_r;
    outv_nxt  = out_valid_r && !out_ch.ready;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    a_ld      = 1'b0;
    dty_ld    = 1'b0;
    out_ld    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_DUTY;
          k_nxt     = '0;
          case (in_ch.func)
            FUNC_TICK: begin
              el_nxt = el_inc;
              if (mode_r == MODE_BLINK && blink_hit) begin
                el_nxt    = '0;
                state_nxt = S_BLINK;
              end else if (mode_r == MODE_FADE && fade_hit) begin
                el_nxt    = '0;
                state_nxt = S_FADE;
              end
            end
            FUNC_SET: begin
              cur_nxt = {(in_ch.lum_valid ? in_ch.lum : cur_r[31:24]),
                         in_ch.blue, in_ch.green, in_ch.red};
            end
            FUNC_ADJ: begin
              cur_nxt[31:24] = lum_adj;
            end
            default: ;
          endcase
        end
      end
      S_BLINK: begin
        wr_en     = 1'b1;
        rd_en     = 1'b1;
        rd_addr   = bidx;
        idx_nxt   = bidx;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cur_nxt   = rd_word;
        state_nxt = S_DUTY;
      end
      S_FADE: begin
        rd_en     = 1'b1;
        rd_addr   = fidx;
        idx_nxt   = fidx;
        phase_nxt = phase_r + 8'd1;
        state_nxt = S_FRDB;
      end
      S_FRDB: begin
        rd_en     = 1'b1;
        rd_addr   = bidx;
        a_ld      = 1'b1;
        k_nxt     = '0;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cur_nxt[k_r*8 +: 8] = sc_q;
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = S_DUTY;
        end
      end
      S_DUTY: begin
        if (k_r != 2'd2) begin
          dty_ld = 1'b1;
          k_nxt  = k_r + 2'd1;
        end else if (!out_valid_r || out_ch.ready) begin
          out_ld    = 1'b1;
          outv_nxt  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      phase_r     <= '0;
      el_r        <= '0;
      out_valid_r <= 1'b0;
      pal_ok_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      el_r        <= el_nxt;
      out_valid_r <= outv_nxt;
      if (wr_en) begin
        pal_ok_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RST;
      interval_r <= INTERVAL_RST;
      count_r    <= COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MODE:     mode_r     <= cfg_ch.data[MODE_W-1:0];
        REG_INTERVAL: interval_r <= cfg_ch.data[EL_W-1:0];
        REG_COUNT:    count_r    <= cfg_ch.data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[idx_r] <= cur_r;
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr];
      rd_ok_r   <= pal_ok_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_r <= rd_word;
    end
    if (dty_ld) begin
      dty_r[k_r[0]] <= sc_q;
    end
    if (out_ld) begin
      duty_red_r   <= dty_r[0];
      duty_green_r <= dty_r[1];
      duty_blue_r  <= sc_q;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.duty_red   = duty_red_r;
  assign out_ch.duty_green = duty_green_r;
  assign out_ch.duty_blue  = duty_blue_r;

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> rd_addr != idx_r)
    else $error("palette read and write hit the same slot");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(idx_r) < CNT_W'(PALETTE_DEPTH))
    else $error("palette index past depth");

  a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLINK || state_r == S_FADE) |-> el_r == '0)
    else $error("elapsed count not cleared on step");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("sequencer idle right after input transfer");

  a_duty_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUTY |-> k_r != 2'd3)
    else $error("duty pass counter out of range");

endmodule

`default_nettype wire
